/* hdl/gravity_weighted_destination_pick_core_defines.svh */
// ----------------------------------------------------------------------------
// Gravity destination pick - assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_WEIGHTED_DESTINATION_PICK_CORE_DEFINES_SVH
`define GRAVITY_WEIGHTED_DESTINATION_PICK_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define GWDP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define GWDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gwdp_pkg.sv */
// ----------------------------------------------------------------------------
// Gravity destination pick - package
// Item layouts, operation and status codes, fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package gwdp_pkg;

   localparam int FIELD_COORD_BITS = 10;
   localparam int POP_BITS         = 24;
   localparam int INDEX_BITS       = 8;
   localparam int RAND_BITS        = 32;
   localparam int OP_BITS          = 2;
   localparam int STATUS_BITS      = 2;
   localparam int ALPHA_BITS       = 2;

   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_PICK  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_WEIGHTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNIFORM  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ERROR    = 2'd2;

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 2'd1;

   // Q.8 power, Q.16 weight = pop * 2^24 / power
   localparam int POW_BITS    = 56;
   localparam int QUOT_BITS   = 48;
   localparam int WEIGHT_BITS = 40;
   localparam int DIST_FRAC   = 8;
   localparam int SQRT_SHIFT  = 16;
   localparam int ONE_Q8      = 256;

   typedef struct packed {
      logic [OP_BITS-1:0]          operation;
      logic [FIELD_COORD_BITS-1:0] port_x;
      logic [FIELD_COORD_BITS-1:0] port_y;
      logic [POP_BITS-1:0]         population;
      logic [INDEX_BITS-1:0]       source_index;
      logic [RAND_BITS-1:0]        random_fraction;
      logic [RAND_BITS-1:0]        random_word;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  destination_index;
      logic [STATUS_BITS-1:0] pick_status;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* hdl/gwdp_chan_if.sv */
// ----------------------------------------------------------------------------
// Gravity destination pick - channel interface
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwdp_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/gravity_weighted_destination_pick_core.sv */
// Pick work: with the defaults each scanned port (all n but the source) takes a
// square root, one 32-step shift-add multiply per power of alpha and a 48-step
// divide; P = 2 passes (1 if the total is zero, then a 32-step modulo), and a
// further shift-add multiply forms the target. Clear, load and op 3 are handled
// in idle without leaving it; one item at a time, as req.ready is high only in idle.
// Reset: port count cleared, exponent set to 1; the port store is not cleared.
// ----------------------------------------------------------------------------
// Gravity destination pick - core
// Store of ports in one synchronous RAM, up to two scans with a shared sqrt,
// shift-add multiplier and restoring divider, result register on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_weighted_destination_pick_core #(
   parameter int MAX_PORT_ENTRIES = 256,
   parameter int COORD_BITS       = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   gwdp_chan_if.sink                       req,
   gwdp_chan_if.source                     rsp,
   input  logic                            csr_write_enable,
   input  logic [gwdp_pkg::ALPHA_BITS-1:0] csr_write_data
);
   import gwdp_pkg::*;

   localparam int IW   = (MAX_PORT_ENTRIES > 1) ? $clog2(MAX_PORT_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_PORT_ENTRIES + 1);
   localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
   localparam int XW   = (COORD_BITS > FIELD_COORD_BITS) ? COORD_BITS : FIELD_COORD_BITS;
   localparam int EW   = 2 * COORD_BITS + POP_BITS;
   localparam int D2W  = 2 * COORD_BITS + 1;
   localparam int VW   = D2W + SQRT_SHIFT;
   localparam int SQW  = VW + (VW % 2);
   localparam int DW   = SQW / 2;
   localparam int TW   = WEIGHT_BITS + CW;
   localparam int MAW  = (POW_BITS > TW) ? POW_BITS : TW;
   localparam int MBW  = (DW > RAND_BITS) ? DW : RAND_BITS;
   localparam int ACW  = MAW + MBW;
   localparam int RW   = POW_BITS + 1;
   localparam int DVW  = QUOT_BITS;
   localparam int STW  = $clog2(((DVW > MBW) ? DVW : MBW) + 1);
   localparam int PHI  = POW_BITS + DIST_FRAC;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_SRC    = 11'b000_0000_0010,
      ST_SCAN   = 11'b000_0000_0100,
      ST_DST    = 11'b000_0000_1000,
      ST_SQUARE = 11'b000_0001_0000,
      ST_SQRT   = 11'b000_0010_0000,
      ST_POW    = 11'b000_0100_0000,
      ST_MUL    = 11'b000_1000_0000,
      ST_DIV    = 11'b001_0000_0000,
      ST_ACCUM  = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

   function automatic logic [INDEX_BITS-1:0] to_dest(input logic [CW-1:0] v);
      logic [CMPW-1:0] e;
      e = CMPW'(v);
      return e[INDEX_BITS-1:0];
   endfunction

   // port store
   logic [EW-1:0] store_mem [MAX_PORT_ENTRIES];
   logic [EW-1:0] rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   logic [EW-1:0] wr_entry;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [ALPHA_BITS-1:0] alpha_ff;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pass_ff, pass_in;
   logic                  tgt_ff, tgt_in;
   logic                  mod_ff, mod_in;
   logic [STW-1:0]        cnt_ff, cnt_in;
   logic [ALPHA_BITS-1:0] k_ff, k_in;
   logic                  rsp_valid_ff;
   logic                  rsp_load;

   logic [CMPW-1:0]        src_ff, src_in;
   logic [RAND_BITS-1:0]   frac_ff, frac_in, word_ff, word_in;
   logic [COORD_BITS-1:0]  sx_ff, sx_in, sy_ff, sy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [POP_BITS-1:0]    pop_ff, pop_in;
   logic [SQW-1:0]         v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [DW-1:0]          dist_ff, dist_in;
   logic [POW_BITS-1:0]    pow_ff, pow_in;
   logic [MAW-1:0]         mul_a_ff, mul_a_in;
   logic [MBW-1:0]         mul_b_ff, mul_b_in;
   logic [ACW-1:0]         acc_ff, acc_in;
   logic [DVW-1:0]         dvd_ff, dvd_in, q_ff, q_in;
   logic [POW_BITS-1:0]    dvs_ff, dvs_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [TW-1:0]          total_ff, total_in, cum_ff, cum_in, target_ff, target_in;
   logic [INDEX_BITS-1:0]  out_dest_ff, out_dest_in;
   logic [STATUS_BITS-1:0] out_status_ff, out_status_in;
   rsp_payload_type        rsp_data_ff;

   logic [XW-1:0]           x_ext, y_ext;
   logic [CMPW-1:0]         req_src;
   logic [COORD_BITS-1:0]   rd_x, rd_y;
   logic [POP_BITS-1:0]     rd_pop, pop1;
   logic [2*COORD_BITS-1:0] sqx, sqy;
   logic [D2W-1:0]          d2;
   logic [SQW-1:0]          sq_trial;
   logic [RW-1:0]           div_trial;
   logic [TW-1:0]           cum_sum;
   logic [CW-1:0]           pick_j, last_idx;

   assign x_ext    = XW'(req.payload.port_x);
   assign y_ext    = XW'(req.payload.port_y);
   assign wr_entry = {req.payload.population, y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0]};
   assign req_src  = CMPW'(req.payload.source_index);
   assign rd_x     = rd_data_ff[COORD_BITS-1:0];
   assign rd_y     = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_pop   = rd_data_ff[EW-1:2*COORD_BITS];
   assign pop1     = (pop_ff == '0) ? POP_BITS'(1) : pop_ff;
   assign sqx      = dx_ff * dx_ff;
   assign sqy      = dy_ff * dy_ff;
   assign d2       = {1'b0, sqx} + {1'b0, sqy};
   assign sq_trial = res_ff + bit_ff;
   assign div_trial = {rem_ff[RW-2:0], dvd_ff[DVW-1]};
   assign cum_sum  = cum_ff + TW'(q_ff[WEIGHT_BITS-1:0]);

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      tgt_in        = tgt_ff;
      mod_in        = mod_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      src_in        = src_ff;
      frac_in       = frac_ff;
      word_in       = word_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      pop_in        = pop_ff;
      v_in          = v_ff;
      res_in        = res_ff;
      bit_in        = bit_ff;
      dist_in       = dist_ff;
      pow_in        = pow_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      acc_in        = acc_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      total_in      = total_ff;
      cum_in        = cum_ff;
      target_in     = target_ff;
      out_dest_in   = out_dest_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      rsp_load      = 1'b0;
      rd_addr       = idx_ff[IW-1:0];
      pick_j        = rem_ff[CW-1:0];
      last_idx      = count_ff - CW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_src[IW-1:0];
            if (req.valid) begin
               unique case (req.payload.operation)
                  OP_CLEAR: count_in = '0;
                  OP_LOAD: begin
                     if (count_ff < CW'(MAX_PORT_ENTRIES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PICK: begin
                     src_in  = req_src;
                     frac_in = req.payload.random_fraction;
                     word_in = req.payload.random_word;
                     if (count_ff < CW'(2) || req_src >= CMPW'(count_ff)) begin
                        out_dest_in   = '0;
                        out_status_in = STATUS_ERROR;
                        state_in      = ST_OUT;
                     end else begin
                        state_in = ST_SRC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SRC: begin
            sx_in    = rd_x;
            sy_in    = rd_y;
            idx_in   = '0;
            pass_in  = 1'b0;
            total_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               if (!pass_ff) begin
                  cnt_in = '0;
                  if (total_ff == '0) begin
                     // uniform fallback: remainder of the divider gives word mod (n-1)
                     dvd_in   = {word_ff, {(DVW-RAND_BITS){1'b0}}};
                     dvs_in   = POW_BITS'(last_idx);
                     rem_in   = '0;
                     mod_in   = 1'b1;
                     state_in = ST_DIV;
                  end else begin
                     mul_a_in = MAW'(total_ff);
                     mul_b_in = MBW'(frac_ff);
                     acc_in   = '0;
                     tgt_in   = 1'b1;
                     state_in = ST_MUL;
                  end
               end else begin
                  if (CMPW'(last_idx) == src_ff) begin
                     last_idx = last_idx - CW'(1);
                  end
                  out_dest_in   = to_dest(last_idx);
                  out_status_in = STATUS_WEIGHTED;
                  state_in      = ST_OUT;
               end
            end else if (CMPW'(idx_ff) == src_ff) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               state_in = ST_DST;
            end
         end
         ST_DST: begin
            dx_in    = (rd_x >= sx_ff) ? rd_x - sx_ff : sx_ff - rd_x;
            dy_in    = (rd_y >= sy_ff) ? rd_y - sy_ff : sy_ff - rd_y;
            pop_in   = rd_pop;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            v_in     = SQW'({d2, {SQRT_SHIFT{1'b0}}});
            res_in   = '0;
            bit_in   = SQW'(1) << (SQW - 2);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               dist_in  = (res_ff < SQW'(ONE_Q8)) ? DW'(ONE_Q8) : res_ff[DW-1:0];
               pow_in   = POW_BITS'(ONE_Q8);
               k_in     = '0;
               state_in = ST_POW;
            end else begin
               if (v_ff >= sq_trial) begin
                  v_in   = v_ff - sq_trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         ST_POW: begin
            cnt_in = '0;
            if (k_ff == alpha_ff) begin
               dvd_in   = {pop1, {(DVW-POP_BITS){1'b0}}};
               dvs_in   = pow_ff;
               rem_in   = '0;
               mod_in   = 1'b0;
               state_in = ST_DIV;
            end else begin
               mul_a_in = MAW'(pow_ff);
               mul_b_in = MBW'(dist_ff);
               acc_in   = '0;
               tgt_in   = 1'b0;
               k_in     = k_ff + ALPHA_BITS'(1);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == STW'(MBW)) begin
               if (tgt_ff) begin
                  target_in = acc_ff[RAND_BITS +: TW];
                  pass_in   = 1'b1;
                  idx_in    = '0;
                  cum_in    = '0;
                  state_in  = ST_SCAN;
               end else begin
                  // saturate once the Q.8 product leaves 64 bits
                  pow_in   = (|acc_ff[ACW-1:PHI]) ? {POW_BITS{1'b1}}
                                                  : acc_ff[PHI-1:DIST_FRAC];
                  state_in = ST_POW;
               end
            end else begin
               acc_in   = (acc_ff << 1) + (mul_b_ff[MBW-1] ? ACW'(mul_a_ff) : ACW'(0));
               mul_b_in = mul_b_ff << 1;
               cnt_in   = cnt_ff + STW'(1);
            end
         end
         ST_DIV: begin
            if (cnt_ff == (mod_ff ? STW'(RAND_BITS) : STW'(DVW))) begin
               if (mod_ff) begin
                  if (CMPW'(pick_j) >= src_ff) begin
                     pick_j = pick_j + CW'(1);
                  end
                  out_dest_in   = to_dest(pick_j);
                  out_status_in = STATUS_UNIFORM;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_ACCUM;
               end
            end else begin
               if (div_trial >= {1'b0, dvs_ff}) begin
                  rem_in = div_trial - {1'b0, dvs_ff};
                  q_in   = {q_ff[DVW-2:0], 1'b1};
               end else begin
                  rem_in = div_trial;
                  q_in   = {q_ff[DVW-2:0], 1'b0};
               end
               dvd_in = dvd_ff << 1;
               cnt_in = cnt_ff + STW'(1);
            end
         end
         ST_ACCUM: begin
            if (!pass_ff) begin
               total_in = total_ff + TW'(q_ff[WEIGHT_BITS-1:0]);
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN;
            end else begin
               cum_in = cum_sum;
               if (cum_sum >= target_ff) begin
                  out_dest_in   = to_dest(idx_ff);
                  out_status_in = STATUS_WEIGHTED;
                  state_in      = ST_OUT;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[IW-1:0]] <= wr_entry;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         alpha_ff     <= ALPHA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write_enable) begin
            alpha_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pass_ff       <= pass_in;
      tgt_ff        <= tgt_in;
      mod_ff        <= mod_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      src_ff        <= src_in;
      frac_ff       <= frac_in;
      word_ff       <= word_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      pop_ff        <= pop_in;
      v_ff          <= v_in;
      res_ff        <= res_in;
      bit_ff        <= bit_in;
      dist_ff       <= dist_in;
      pow_ff        <= pow_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      acc_ff        <= acc_in;
      dvd_ff        <= dvd_in;
      dvs_ff        <= dvs_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      total_ff      <= total_in;
      cum_ff        <= cum_in;
      target_ff     <= target_in;
      out_dest_ff   <= out_dest_in;
      out_status_ff <= out_status_in;
      if (rsp_load) begin
         rsp_data_ff.destination_index <= out_dest_ff;
         rsp_data_ff.pick_status       <= out_status_ff;
      end
   end

endmodule

`default_nettype wire

/* hdl/gwdp_checker.sv */
// ----------------------------------------------------------------------------
// Gravity destination pick - port checker
// Watches the channels of the core over time; bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gravity_weighted_destination_pick_core_defines.svh"

module gwdp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [gwdp_pkg::OP_BITS-1:0] req_op,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input gwdp_pkg::rsp_payload_type rsp_payload
);
   import gwdp_pkg::*;

   `GWDP_ASSERT_NEXT(a_rsp_valid_held, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped")
   `GWDP_ASSERT_NEXT(a_rsp_data_held, rsp_valid && !rsp_ready, $stable(rsp_payload), "rsp item changed while stalled")
   `GWDP_ASSERT_NEXT(a_pick_busy, req_valid && req_ready && req_op == OP_PICK, !req_ready, "pick item did not occupy the core")
   `GWDP_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), $past(!req_ready), "result appeared without a pick in flight")

endmodule

bind gravity_weighted_destination_pick_core gwdp_checker u_gwdp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .req_op      (req.payload.operation),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

`default_nettype wire
